// ===== rtl/oale_pkg.sv =====
// Shared types and constants for the ordered array list engine.
package oale_pkg;

   localparam int FUNC_W = 3;
   localparam int POS_W  = 5;
   localparam int VAL_W  = 32;
   localparam int LEN_W  = 5;

   typedef enum logic [FUNC_W-1:0] {
      FN_CLEAR  = 3'd0,
      FN_INSERT = 3'd1,
      FN_DELETE = 3'd2,
      FN_GET    = 3'd3,
      FN_LOCATE = 3'd4,
      FN_PREV   = 3'd5,
      FN_NEXT   = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      func_type           func;
      logic [POS_W-1:0]   position;
      logic [VAL_W-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [VAL_W-1:0]   data_out;
      logic [POS_W-1:0]   found_position;
      logic [LEN_W-1:0]   list_length;
      logic               is_empty;
   } rsp_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic               capture;
      logic               commit;
      func_type           func;
      logic [POS_W-1:0]   position;
   } cell_cmd_type;

endpackage

// ===== rtl/oale_cell.sv =====
// One list slot: holds an element, compares it, shifts with its neighbors.
module oale_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int CAPACITY   = 16,
   parameter int INDEX      = 0
) (
   input  logic                              clock,
   input  oale_pkg::cell_cmd_type            cmd,
   input  logic [$clog2(CAPACITY+1)-1:0]     count,
   input  logic [DATA_WIDTH-1:0]             key,
   input  logic [DATA_WIDTH-1:0]             left_entry,
   input  logic [DATA_WIDTH-1:0]             right_entry,
   input  logic                              left_first,
   input  logic                              right_first,
   output logic [DATA_WIDTH-1:0]             entry,
   output logic [DATA_WIDTH-1:0]             pick_data,
   output logic                              match
);
   import oale_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CMP_W-1:0] SLOT = CMP_W'(INDEX + 1);

   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic                  match_ff, match_in;
   logic [CMP_W-1:0]      pos_c, cnt_c;
   logic                  at_pos, live, pick;

   assign pos_c  = CMP_W'(cmd.position);
   assign cnt_c  = CMP_W'(count);
   assign at_pos = (SLOT == pos_c);
   assign live   = (SLOT <= cnt_c);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.commit) begin
         case (cmd.func)
            FN_INSERT: begin
               if (at_pos) begin
                  entry_in = key;
               end else if ((SLOT > pos_c) && (SLOT <= cnt_c + CMP_W'(1))) begin
                  entry_in = left_entry;
               end
            end
            FN_DELETE: begin
               if ((SLOT >= pos_c) && (SLOT < cnt_c)) begin
                  entry_in = right_entry;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      match_in = match_ff;
      if (cmd.capture) begin
         match_in = live && (entry_ff == key);
      end
   end

   // The previous element of the first match sits to its left, so this
   // cell answers when its right neighbor holds the first match.
   always_comb begin
      case (cmd.func)
         FN_DELETE, FN_GET: pick = at_pos;
         FN_PREV:           pick = right_first;
         FN_NEXT:           pick = left_first;
         default:           pick = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry     = entry_ff;
   assign match     = match_ff;
   assign pick_data = pick ? entry_ff : '0;

endmodule

// ===== rtl/ordered_array_list_engine.sv =====
// Ordered array list engine: a fixed-capacity list held in a row of cells.
// When an item is accepted every cell compares its element with the masked
// value and registers the result; in the busy state that follows, the first
// match is isolated, the selected element is read out, the cells shift for
// an insert or delete, and the result register is loaded. The busy state
// holds while the result register still holds a result that has not been
// taken; no new item is accepted until the busy state ends.
// A new item may be accepted while a result waits on the output.
module ordered_array_list_engine #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  oale_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output oale_pkg::rsp_type rsp_item
);
   import oale_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int NB    = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_BUSY = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  capture, out_free, commit;
   logic [VAL_W-1:0]      key_src;
   logic [DATA_WIDTH-1:0] key;
   cell_cmd_type          cmd;

   logic [DATA_WIDTH-1:0] entry_arr [CAPACITY];
   logic [DATA_WIDTH-1:0] pick_arr  [CAPACITY];
   logic [CAPACITY-1:0]   match_vec, first_vec;

   logic [CNT_W-1:0]      found_slot;
   logic                  any_match;
   logic [DATA_WIDTH-1:0] or_data;
   logic [CMP_W-1:0]      pos_c, cnt_c;
   status_type            status_c;
   logic                  search_op;

   assign req_ready = (state_ff == S_IDLE);
   assign capture   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == S_BUSY) && out_free;

   // The comparison runs on the arriving item; the commit uses the held one.
   assign key_src = req_ready ? req_item.value : req_ff.value;
   always_comb begin
      key = '0;
      key[NB-1:0] = key_src[NB-1:0];
   end

   always_comb begin
      cmd.capture  = capture;
      cmd.commit   = commit && (status_c == ST_OK);
      cmd.func     = req_ff.func;
      cmd.position = req_ff.position;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_e, right_e;
      logic                  left_f, right_f;

      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_f = 1'b0;
      end else begin : g_mid_l
         assign left_e = entry_arr[i-1];
         assign left_f = first_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_e = '0;
         assign right_f = 1'b0;
      end else begin : g_mid_r
         assign right_e = entry_arr[i+1];
         assign right_f = first_vec[i+1];
      end

      oale_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CAPACITY   (CAPACITY),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .key         (key),
         .left_entry  (left_e),
         .right_entry (right_e),
         .left_first  (left_f),
         .right_first (right_f),
         .entry       (entry_arr[i]),
         .pick_data   (pick_arr[i]),
         .match       (match_vec[i])
      );
   end

   // Lowest set bit of the match vector is the first match.
   assign first_vec = match_vec & (~match_vec + CAPACITY'(1));
   assign any_match = |match_vec;

   always_comb begin
      found_slot = '0;
      or_data    = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_vec[i]) begin
            found_slot = found_slot | CNT_W'(i + 1);
         end
         or_data = or_data | pick_arr[i];
      end
   end

   assign pos_c = CMP_W'(req_ff.position);
   assign cnt_c = CMP_W'(count_ff);

   always_comb begin
      status_c  = ST_OK;
      count_in  = count_ff;
      search_op = 1'b0;
      case (req_ff.func)
         FN_CLEAR: begin
            if (commit) begin
               count_in = '0;
            end
         end
         FN_INSERT: begin
            if ((pos_c == '0) || (pos_c > cnt_c + CMP_W'(1))) begin
               status_c = ST_BAD_POS;
            end else if (cnt_c >= CMP_W'(CAPACITY)) begin
               status_c = ST_FULL;
            end else if (commit) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         FN_DELETE: begin
            if ((pos_c == '0) || (pos_c > cnt_c)) begin
               status_c = ST_BAD_POS;
            end else if (commit) begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         FN_GET: begin
            if ((pos_c == '0) || (pos_c > cnt_c)) begin
               status_c = ST_BAD_POS;
            end
         end
         FN_LOCATE, FN_PREV, FN_NEXT: begin
            search_op = 1'b1;
            if (!any_match) begin
               status_c = ST_MISSING;
            end else if ((req_ff.func == FN_PREV) && first_vec[0]) begin
               status_c = ST_MISSING;
            end else if ((req_ff.func == FN_NEXT) && (found_slot == count_ff)) begin
               status_c = ST_MISSING;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      if (commit) begin
         rsp_valid_in           = 1'b1;
         rsp_in.status          = status_c;
         rsp_in.data_out        = '0;
         if (status_c == ST_OK) begin
            rsp_in.data_out[NB-1:0] = or_data[NB-1:0];
         end
         rsp_in.found_position  = (search_op && any_match) ? POS_W'(found_slot) : '0;
         rsp_in.list_length     = LEN_W'(count_in);
         rsp_in.is_empty        = (count_in == '0);
      end
   end

   always_comb begin
      req_in   = req_ff;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (capture) begin
               req_in   = req_item;
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_BUSY))
      else $error("result appeared without a committed item");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("list length exceeds capacity");

   // Match flags are only meaningful once an item has been captured.
   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUSY) |-> $onehot0(first_vec))
      else $error("more than one first match");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (commit && (req_ff.func == FN_INSERT) && (status_c == ST_OK))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("successful insert did not grow the list");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the ordered array list engine with a list predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import oale_pkg::*;

   localparam int LIST_CAPACITY = 16;
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_ITEMS  = 800;

   // Operation code that the block ignores.
   localparam logic [FUNC_W-1:0] FN_SPARE = 3'd7;

   typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED, MIX_NOISE} mix_type;

   // Shadow copy of the list; predicts one result per accepted item.
   class list_tracker;
      logic [VAL_W-1:0] shadow_entries [LIST_CAPACITY];
      int               shadow_count;
      rsp_type          pending_results [$];
      int               failures;

      function new();
         shadow_count = 0;
         failures     = 0;
      endfunction

      function void apply_request(req_type r);
         rsp_type e;
         int      pos;
         int      m;
         int      k;
         e   = '0;
         pos = int'(r.position);
         case (r.func)
            FN_CLEAR: begin
               shadow_count = 0;
            end
            FN_INSERT: begin
               if (pos < 1 || pos > shadow_count + 1) begin
                  e.status = ST_BAD_POS;
               end else if (shadow_count >= LIST_CAPACITY) begin
                  e.status = ST_FULL;
               end else begin
                  for (k = shadow_count; k > pos - 1; k--)
                     shadow_entries[k] = shadow_entries[k-1];
                  shadow_entries[pos-1] = r.value;
                  shadow_count++;
               end
            end
            FN_DELETE: begin
               if (pos < 1 || pos > shadow_count) begin
                  e.status = ST_BAD_POS;
               end else begin
                  e.data_out = shadow_entries[pos-1];
                  for (k = pos - 1; k + 1 < shadow_count; k++)
                     shadow_entries[k] = shadow_entries[k+1];
                  shadow_count--;
               end
            end
            FN_GET: begin
               if (pos < 1 || pos > shadow_count)
                  e.status = ST_BAD_POS;
               else
                  e.data_out = shadow_entries[pos-1];
            end
            FN_LOCATE, FN_PREV, FN_NEXT: begin
               m = 0;
               while (m < shadow_count && shadow_entries[m] != r.value)
                  m++;
               if (m >= shadow_count) begin
                  e.status = ST_MISSING;
               end else begin
                  e.found_position = POS_W'(m + 1);
                  if (r.func == FN_PREV) begin
                     if (m == 0)
                        e.status = ST_MISSING;
                     else
                        e.data_out = shadow_entries[m-1];
                  end else if (r.func == FN_NEXT) begin
                     if (m + 1 >= shadow_count)
                        e.status = ST_MISSING;
                     else
                        e.data_out = shadow_entries[m+1];
                  end
               end
            end
            default: begin
            end
         endcase
         e.list_length = LEN_W'(shadow_count);
         e.is_empty    = (shadow_count == 0);
         pending_results.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display({"%0t: result with nothing expected: ",
                         "status %0d data %h found %0d len %0d empty %0d"},
                        $realtime, got.status, got.data_out, got.found_position,
                        got.list_length, got.is_empty);
            return;
         end
         e = pending_results.pop_front();
         if (got.status !== e.status || got.data_out !== e.data_out ||
             got.found_position !== e.found_position ||
             got.list_length !== e.list_length || got.is_empty !== e.is_empty) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display({"%0t: mismatch: expected status %0d data %h found %0d ",
                         "len %0d empty %0d, got status %0d data %h found %0d ",
                         "len %0d empty %0d"},
                        $realtime, e.status, e.data_out, e.found_position, e.list_length,
                        e.is_empty, got.status, got.data_out, got.found_position,
                        got.list_length, got.is_empty);
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   list_tracker tracker = new();
   bit          sender_burst   = 1'b0;
   bit          receiver_burst = 1'b0;

   ordered_array_list_engine #(
      .CAPACITY(LIST_CAPACITY),
      .DATA_WIDTH(VAL_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic req_type pack_item(logic [FUNC_W-1:0] f, int pos, logic [VAL_W-1:0] v);
      req_type r;
      r.func     = func_type'(f);
      r.position = POS_W'(pos);
      r.value    = v;
      return r;
   endfunction

   // Valid stays high across back-to-back items; it is lowered only for a gap.
   task automatic send(req_type r);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      do @(posedge clock); while (!req_ready);
      tracker.apply_request(r);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_results.size() != 0) @(posedge clock);
   endtask

   // Search values mostly hit stored entries so that matches are common.
   function automatic logic [VAL_W-1:0] pick_value(bit search);
      logic [3:0] idx;
      if (search && tracker.shadow_count > 0 && $urandom_range(0, 9) < 7)
         return tracker.shadow_entries[$urandom_range(0, tracker.shadow_count - 1)];
      if ($urandom_range(0, 1) == 0) begin
         idx = 4'($urandom_range(0, 15));
         return {8{idx}};
      end
      return $urandom;
   endfunction

   function automatic req_type make_item(mix_type mix);
      int               roll;
      int               cnt;
      int               pos;
      logic [FUNC_W-1:0] f;
      roll = $urandom_range(0, 99);
      cnt  = tracker.shadow_count;
      if (mix == MIX_NOISE)
         return pack_item(FUNC_W'($urandom_range(0, 7)), $urandom_range(0, 31),
                          pick_value(1'($urandom_range(0, 1))));
      case (mix)
         MIX_GROW:
            f = roll < 60 ? FN_INSERT : roll < 72 ? FN_DELETE : roll < 82 ? FN_GET :
                FUNC_W'($urandom_range(FN_LOCATE, FN_NEXT));
         MIX_SHRINK:
            f = roll < 15 ? FN_INSERT : roll < 60 ? FN_DELETE : roll < 72 ? FN_GET :
                roll < 97 ? FUNC_W'($urandom_range(FN_LOCATE, FN_NEXT)) : FN_CLEAR;
         default:
            f = roll < 35 ? FN_INSERT : roll < 65 ? FN_DELETE : roll < 77 ? FN_GET :
                roll < 97 ? FUNC_W'($urandom_range(FN_LOCATE, FN_NEXT)) :
                roll < 99 ? FN_CLEAR : FN_SPARE;
      endcase
      if ($urandom_range(0, 9) == 0)
         pos = $urandom_range(0, 31);
      else if (f == FN_INSERT)
         pos = $urandom_range(1, cnt + 1);
      else if (cnt > 0)
         pos = $urandom_range(1, cnt);
      else
         pos = $urandom_range(0, 31);
      return pack_item(f, pos, pick_value(f != FN_INSERT));
   endfunction

   initial begin
      int      stall;
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_burst ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_result(rsp_item);
         if ($urandom_range(0, 49) == 0)
            receiver_burst = ~receiver_burst;
      end
   end

   initial begin
      int      sent;
      int      phase;
      int      span;
      mix_type mix;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty list, bad positions, neighbours at both ends, unused code, clear.
      send(pack_item(FN_GET, 1, 32'h0));
      send(pack_item(FN_DELETE, 1, 32'h0));
      send(pack_item(FN_LOCATE, 0, 32'h0));
      send(pack_item(FN_NEXT, 0, 32'h0));
      send(pack_item(FN_INSERT, 0, 32'h1));
      send(pack_item(FN_INSERT, 2, 32'h1));
      send(pack_item(FN_INSERT, 1, 32'h0000_0000));
      send(pack_item(FN_INSERT, 2, 32'hFFFF_FFFF));
      send(pack_item(FN_INSERT, 2, 32'h5A5A_5A5A));
      send(pack_item(FN_INSERT, 1, 32'hA5A5_A5A5));
      send(pack_item(FN_INSERT, 5, 32'h0000_0000));
      send(pack_item(FN_GET, 5, 32'h0));
      send(pack_item(FN_GET, 6, 32'h0));
      send(pack_item(FN_GET, 31, 32'h0));
      send(pack_item(FN_LOCATE, 0, 32'h0000_0000));
      send(pack_item(FN_PREV, 0, 32'hA5A5_A5A5));
      send(pack_item(FN_NEXT, 0, 32'h0000_0000));
      send(pack_item(FN_PREV, 0, 32'hFFFF_FFFF));
      send(pack_item(FN_DELETE, 5, 32'h0));
      send(pack_item(FN_NEXT, 31, 32'hFFFF_FFFF));
      send(pack_item(FN_DELETE, 2, 32'h0));
      send(pack_item(FN_LOCATE, 0, 32'h1234_5678));
      send(pack_item(FN_SPARE, 31, 32'hFFFF_FFFF));
      send(pack_item(FN_DELETE, 1, 32'h0));
      send(pack_item(FN_CLEAR, 0, 32'h0));
      send(pack_item(FN_GET, 1, 32'h0));

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase == 0 || $urandom_range(0, 3) == 0)
            drain_results();
         sender_burst = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2: mix = MIX_GROW;
            3, 4:    mix = MIX_SHRINK;
            5:       mix = MIX_NOISE;
            default: mix = MIX_BALANCED;
         endcase
         span = $urandom_range(20, 60);
         repeat (span) begin
            send(make_item(mix));
            sent++;
         end
         phase++;
      end
      req_valid <= 1'b0;

      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
